FILE: rtl/zfh_pkg.sv
// Shared types and constants for the zonal flocking heading block.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps

package zfh_pkg;

    localparam int AddrWidth = 5;
    localparam int QueueDepth = 2;
    localparam int QueueAw = $clog2(QueueDepth);
    localparam int RootSteps = 30;
    localparam int DivSteps = 17;
    localparam int StepCw = 5;

    localparam logic [2:0] REG_REPEL_RADIUS   = 3'd0;
    localparam logic [2:0] REG_ALIGN_RADIUS   = 3'd1;
    localparam logic [2:0] REG_ATTRACT_RADIUS = 3'd2;
    localparam logic [2:0] REG_ALIGN_WEIGHT   = 3'd3;
    localparam logic [2:0] REG_VIEW_COS_LIMIT = 3'd4;
    localparam logic [2:0] REG_MODE_BITS      = 3'd5;
    localparam logic [2:0] REG_BOX_WIDTH      = 3'd6;
    localparam logic [2:0] REG_BOX_HEIGHT     = 3'd7;

    localparam logic [2:0] ZONE_NONE    = 3'd0;
    localparam logic [2:0] ZONE_REPEL   = 3'd1;
    localparam logic [2:0] ZONE_MIXED   = 3'd2;
    localparam logic [2:0] ZONE_ALIGN   = 3'd3;
    localparam logic [2:0] ZONE_ATTRACT = 3'd4;

    localparam int MODE_WRAP = 0;
    localparam int MODE_VICSEK = 1;

    typedef struct packed {
        logic [19:0]        repel_radius;
        logic [19:0]        align_radius;
        logic [19:0]        attract_radius;
        logic [14:0]        align_weight;
        logic signed [15:0] view_cos_limit;
        logic [1:0]         mode_bits;
        logic [19:0]        box_width;
        logic [19:0]        box_height;
    } t_cfg;

    // One classified neighbor as it travels from front to back.
    typedef struct packed {
        logic signed [20:0] rx;
        logic signed [20:0] ry;
        logic signed [15:0] fcos;
        logic signed [15:0] fsin;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic               skip;
        logic               repel_hit;
        logic               lt_ra;
        logic               align_ok;
        logic               attract_ok;
        logic               last;
    } t_rec;

endpackage

FILE: rtl/zfh_fifo.sv
// Short record queue between the front and back sections.
// Depends on zfh_pkg for the record type.
`timescale 1ns / 1ps

module zfh_fifo import zfh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_data,
    input  logic i_pop,
    output t_rec o_data,
    output logic o_full,
    output logic o_empty
);

    t_rec               r_mem [QueueDepth];
    logic [QueueAw-1:0] r_wp;
    logic [QueueAw-1:0] r_rp;
    logic [QueueAw:0]   r_cnt;

    assign o_full  = (r_cnt == (QueueAw+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QueueAw+1)'(i_push && !o_full)
                           - (QueueAw+1)'(i_pop && !o_empty);
        end
    end

endmodule

FILE: rtl/zfh_front.sv
// Front section: take a transfer, form the wrapped offset and squared distance,
// class it against the zone radii and push the record. Depends on zfh_pkg.
`timescale 1ns / 1ps

module zfh_front import zfh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [19:0]        i_focal_x,
    input  logic [19:0]        i_focal_y,
    input  logic signed [15:0] i_focal_cos,
    input  logic signed [15:0] i_focal_sin,
    input  logic [19:0]        i_other_x,
    input  logic [19:0]        i_other_y,
    input  logic signed [23:0] i_other_vx,
    input  logic signed [23:0] i_other_vy,
    input  logic               i_is_self,
    input  logic               i_last,
    output logic               o_push,
    output t_rec               o_rec,
    input  logic               i_full
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_WRAP = 4'b0010,
        F_SQR  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;

    logic [19:0]        r_fx, r_fy, r_ox, r_oy;
    logic signed [15:0] r_cos, r_sin;
    logic signed [23:0] r_vx, r_vy;
    logic               r_self, r_last;
    logic signed [20:0] r_rx, r_ry;
    logic [41:0]        r_sx, r_sy;
    logic [39:0]        r_rd, r_ra, r_rat;

    logic signed [20:0] raw_x, raw_y, wrap_x, wrap_y;
    logic [41:0]        d2;
    logic               vic;

    function automatic logic signed [20:0] wrap_axis(input logic signed [20:0] r,
                                                     input logic [19:0] w);
        logic signed [22:0] r2;
        logic signed [22:0] ws;
        begin
            r2 = 23'(r) <<< 1;
            ws = $signed({3'b000, w});
            if (r2 > ws) begin
                wrap_axis = r - $signed({1'b0, w});
            end else if (r2 <= -ws) begin
                wrap_axis = r + $signed({1'b0, w});
            end else begin
                wrap_axis = r;
            end
        end
    endfunction

    assign raw_x  = $signed({1'b0, r_ox}) - $signed({1'b0, r_fx});
    assign raw_y  = $signed({1'b0, r_oy}) - $signed({1'b0, r_fy});
    assign wrap_x = i_cfg.mode_bits[MODE_WRAP] ? wrap_axis(raw_x, i_cfg.box_width)  : raw_x;
    assign wrap_y = i_cfg.mode_bits[MODE_WRAP] ? wrap_axis(raw_y, i_cfg.box_height) : raw_y;
    assign d2     = r_sx + r_sy;
    assign vic    = i_cfg.mode_bits[MODE_VICSEK];

    assign o_stall = (r_state != F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;

    always_comb begin
        o_rec.rx         = r_rx;
        o_rec.ry         = r_ry;
        o_rec.fcos       = r_cos;
        o_rec.fsin       = r_sin;
        o_rec.vx         = r_vx;
        o_rec.vy         = r_vy;
        o_rec.skip       = r_self || (d2 == '0);
        o_rec.repel_hit  = !vic && (i_cfg.repel_radius != '0) && (d2 < 42'(r_rd));
        o_rec.lt_ra      = (d2 < 42'(r_ra));
        o_rec.align_ok   = (i_cfg.align_radius != '0) && (d2 >= 42'(r_rd));
        o_rec.attract_ok = !vic && (i_cfg.attract_radius != '0) && (d2 >= 42'(r_rd))
                           && (d2 >= 42'(r_ra)) && (d2 < 42'(r_rat));
        o_rec.last       = r_last;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (i_valid) n_state = F_WRAP;
            F_WRAP: n_state = F_SQR;
            F_SQR:  n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_fx   <= i_focal_x;
            r_fy   <= i_focal_y;
            r_ox   <= i_other_x;
            r_oy   <= i_other_y;
            r_cos  <= i_focal_cos;
            r_sin  <= i_focal_sin;
            r_vx   <= i_other_vx;
            r_vy   <= i_other_vy;
            r_self <= i_is_self;
            r_last <= i_last;
        end
        if (r_state == F_WRAP) begin
            r_rx <= wrap_x;
            r_ry <= wrap_y;
        end
        if (r_state == F_SQR) begin
            r_sx  <= 42'(r_rx * r_rx);
            r_sy  <= 42'(r_ry * r_ry);
            r_rd  <= i_cfg.repel_radius * i_cfg.repel_radius;
            r_ra  <= i_cfg.align_radius * i_cfg.align_radius;
            r_rat <= i_cfg.attract_radius * i_cfg.attract_radius;
        end
    end

endmodule

FILE: rtl/zfh_unit.sv
// Multi-cycle Q1.14 unit vector engine: normalize, square, bit-serial root,
// then two restoring dividers sharing the root. Depends on zfh_pkg.
`timescale 1ns / 1ps

module zfh_unit import zfh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    output logic               o_done,
    output logic               o_nz,
    output logic signed [15:0] o_ux,
    output logic signed [15:0] o_uy
);

    typedef enum logic [6:0] {
        U_IDLE = 7'b0000001,
        U_NORM = 7'b0000010,
        U_SQR  = 7'b0000100,
        U_SUM  = 7'b0001000,
        U_ROOT = 7'b0010000,
        U_DIV  = 7'b0100000,
        U_DONE = 7'b1000000
    } t_ustate;

    t_ustate r_state;

    logic [31:0]       r_ax, r_ay;
    logic              r_negx, r_negy, r_nz;
    logic [41:0]       r_px, r_py;
    logic [59:0]       r_n;
    logic [31:0]       r_rem;
    logic [29:0]       r_root;
    logic [StepCw-1:0] r_cnt;
    logic [30:0]       r_dremx, r_dremy;
    logic [16:0]       r_lox, r_loy;
    logic [16:0]       r_qx, r_qy;

    logic [31:0] mag_x, mag_y, m;
    logic [33:0] rem_sh, trial;
    logic [43:0] num_x, num_y;
    logic [31:0] dsh_x, dsh_y;
    logic [14:0] cap_x, cap_y;

    assign mag_x = i_x[31] ? 32'(-i_x) : 32'(i_x);
    assign mag_y = i_y[31] ? 32'(-i_y) : 32'(i_y);
    assign m     = (r_ax > r_ay) ? r_ax : r_ay;

    assign rem_sh = {r_rem, r_n[59:58]};
    assign trial  = {2'b00, r_root, 2'b01};

    assign num_x = {r_ax[20:0], 22'd0} + 44'(r_root >> 1);
    assign num_y = {r_ay[20:0], 22'd0} + 44'(r_root >> 1);
    assign dsh_x = {r_dremx, r_lox[16]};
    assign dsh_y = {r_dremy, r_loy[16]};

    assign cap_x = (r_qx > 17'd16384) ? 15'd16384 : r_qx[14:0];
    assign cap_y = (r_qy > 17'd16384) ? 15'd16384 : r_qy[14:0];

    assign o_done = (r_state == U_DONE);
    assign o_nz   = r_nz;
    assign o_ux   = !r_nz ? '0 : (r_negx ? -$signed({1'b0, cap_x}) : $signed({1'b0, cap_x}));
    assign o_uy   = !r_nz ? '0 : (r_negy ? -$signed({1'b0, cap_y}) : $signed({1'b0, cap_y}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_state <= (i_x == '0 && i_y == '0) ? U_DONE : U_NORM;
                    end
                end
                U_NORM: if (m[31:21] == '0 && m[20]) r_state <= U_SQR;
                U_SQR:  r_state <= U_SUM;
                U_SUM:  r_state <= U_ROOT;
                U_ROOT: if (r_cnt == StepCw'(RootSteps - 1)) r_state <= U_DIV;
                U_DIV:  if (r_cnt == StepCw'(DivSteps)) r_state <= U_DONE;
                U_DONE: r_state <= U_IDLE;
                default: r_state <= U_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    r_ax   <= mag_x;
                    r_ay   <= mag_y;
                    r_negx <= i_x[31];
                    r_negy <= i_y[31];
                    r_nz   <= !(i_x == '0 && i_y == '0);
                end
            end
            U_NORM: begin
                // truncating shifts, one bit a cycle
                if (m[31:21] != '0) begin
                    r_ax <= r_ax >> 1;
                    r_ay <= r_ay >> 1;
                end else if (!m[20]) begin
                    r_ax <= r_ax << 1;
                    r_ay <= r_ay << 1;
                end
            end
            U_SQR: begin
                r_px <= r_ax[20:0] * r_ax[20:0];
                r_py <= r_ay[20:0] * r_ay[20:0];
            end
            U_SUM: begin
                r_n    <= {1'b0, (43'(r_px) + 43'(r_py)), 16'd0};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            U_ROOT: begin
                r_n <= r_n << 2;
                if (rem_sh >= trial) begin
                    r_rem  <= 32'(rem_sh - trial);
                    r_root <= {r_root[28:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[31:0];
                    r_root <= {r_root[28:0], 1'b0};
                end
                if (r_cnt == StepCw'(RootSteps - 1)) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            U_DIV: begin
                // first cycle loads the numerator; the high part is below the root
                if (r_cnt == '0) begin
                    r_dremx <= {4'd0, num_x[43:17]};
                    r_dremy <= {4'd0, num_y[43:17]};
                    r_lox   <= num_x[16:0];
                    r_loy   <= num_y[16:0];
                    r_qx    <= '0;
                    r_qy    <= '0;
                end else begin
                    r_lox <= r_lox << 1;
                    r_loy <= r_loy << 1;
                    if (dsh_x >= {2'b00, r_root}) begin
                        r_dremx <= 31'(dsh_x - {2'b00, r_root});
                        r_qx    <= {r_qx[15:0], 1'b1};
                    end else begin
                        r_dremx <= dsh_x[30:0];
                        r_qx    <= {r_qx[15:0], 1'b0};
                    end
                    if (dsh_y >= {2'b00, r_root}) begin
                        r_dremy <= 31'(dsh_y - {2'b00, r_root});
                        r_qy    <= {r_qy[15:0], 1'b1};
                    end else begin
                        r_dremy <= dsh_y[30:0];
                        r_qy    <= {r_qy[15:0], 1'b0};
                    end
                end
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/zfh_back.sv
// Back section: zone gating, view test, saturating sums and the final heading.
// Depends on zfh_pkg and drives the shared zfh_unit.
`timescale 1ns / 1ps

module zfh_back import zfh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_rec               i_rec,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y,
    output logic [2:0]         o_zone_used
);

    typedef enum logic [9:0] {
        B_IDLE = 10'b0000000001,
        B_OFF  = 10'b0000000010,
        B_CMP  = 10'b0000000100,
        B_VEL  = 10'b0000001000,
        B_FREP = 10'b0000010000,
        B_FAL  = 10'b0000100000,
        B_FAT  = 10'b0001000000,
        B_MIX  = 10'b0010000000,
        B_OUT  = 10'b0100000000,
        B_NEXT = 10'b1000000000
    } t_bstate;

    typedef enum logic [2:0] {
        K_REPEL   = 3'b001,
        K_ALIGN   = 3'b010,
        K_ATTRACT = 3'b100
    } t_kind;

    t_bstate r_state;
    t_kind   r_kind;
    t_rec    r_rec;

    logic signed [31:0] r_rsx, r_rsy, r_asx, r_asy, r_tsx, r_tsy;
    logic               r_seen;
    logic               r_ustart;
    logic signed [31:0] r_uin_x, r_uin_y;
    logic signed [15:0] r_rux, r_ruy, r_aux, r_auy, r_tux, r_tuy;
    logic               r_hrep, r_hal, r_hat;
    logic signed [31:0] r_pc, r_ps;
    logic signed [31:0] r_max, r_may, r_mtx, r_mty;
    logic               r_ovalid;
    logic signed [15:0] r_dx, r_dy;
    logic [2:0]         r_zone;

    logic               u_done, u_nz;
    logic signed [15:0] u_x, u_y;

    logic               vic, cls_rep, cls_al, cls_at;
    logic signed [32:0] dot;
    logic signed [32:0] dot_c;
    logic signed [32:0] lim;
    logic [14:0]        w;
    logic [14:0]        wc;
    logic signed [15:0] mix_x, mix_y;

    zfh_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_ustart),
        .i_x     (r_uin_x),
        .i_y     (r_uin_y),
        .o_done  (u_done),
        .o_nz    (u_nz),
        .o_ux    (u_x),
        .o_uy    (u_y)
    );

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [15:0] b);
        logic signed [32:0] s;
        begin
            s = 33'(a) + 33'(b);
            if (s > 33'sh0_7FFF_FFFF) begin
                sat_add = 32'sh7FFF_FFFF;
            end else if (s < -33'sh0_8000_0000) begin
                sat_add = 32'sh8000_0000;
            end else begin
                sat_add = s[31:0];
            end
        end
    endfunction

    function automatic logic signed [15:0] round_q14(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        logic [32:0]        mag;
        logic [18:0]        q;
        logic [14:0]        c;
        begin
            s   = 33'(a) + 33'(b);
            mag = s[32] ? 33'(-s) : 33'(s);
            q   = 19'((mag + 33'd8192) >> 14);
            c   = (q > 19'd16384) ? 15'd16384 : q[14:0];
            round_q14 = s[32] ? -$signed({1'b0, c}) : $signed({1'b0, c});
        end
    endfunction

    assign vic     = i_cfg.mode_bits[MODE_VICSEK];
    assign cls_rep = !i_rec.skip && i_rec.repel_hit;
    assign cls_al  = !i_rec.skip && !cls_rep && i_rec.lt_ra
                     && (vic || (!r_seen && i_rec.align_ok));
    assign cls_at  = !i_rec.skip && !cls_rep && !cls_al && !r_seen && i_rec.attract_ok;

    assign dot   = 33'(r_pc) + 33'(r_ps);
    assign dot_c = (dot > 33'sd268435456) ? 33'sd268435456 :
                   (dot < -33'sd268435456) ? -33'sd268435456 : dot;
    assign lim   = 33'(i_cfg.view_cos_limit) <<< 14;

    assign w     = (i_cfg.align_weight > 15'd16384) ? 15'd16384 : i_cfg.align_weight;
    assign wc    = 15'd16384 - w;
    assign mix_x = round_q14(r_max, r_mtx);
    assign mix_y = round_q14(r_may, r_mty);

    assign o_pop       = (r_state == B_IDLE) && !i_empty;
    assign o_valid     = r_ovalid;
    assign o_dir_x     = r_dx;
    assign o_dir_y     = r_dy;
    assign o_zone_used = r_zone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ustart <= 1'b0;
            r_ovalid <= 1'b0;
            r_seen   <= 1'b0;
            r_rsx    <= '0;
            r_rsy    <= '0;
            r_asx    <= '0;
            r_asy    <= '0;
            r_tsx    <= '0;
            r_tsy    <= '0;
        end else begin
            r_ustart <= 1'b0;
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_rec   <= i_rec;
                        r_uin_x <= 32'(i_rec.rx);
                        r_uin_y <= 32'(i_rec.ry);
                        if (cls_rep || cls_al || cls_at) begin
                            r_ustart <= 1'b1;
                            r_kind   <= cls_rep ? K_REPEL : (cls_al ? K_ALIGN : K_ATTRACT);
                            r_state  <= B_OFF;
                        end else begin
                            r_state <= B_NEXT;
                        end
                    end
                end
                B_OFF: begin
                    if (u_done) begin
                        if (r_kind == K_REPEL) begin
                            r_rsx   <= sat_add(r_rsx, -u_x);
                            r_rsy   <= sat_add(r_rsy, -u_y);
                            r_seen  <= 1'b1;
                            r_state <= B_NEXT;
                        end else begin
                            r_pc    <= 32'(r_rec.fcos * u_x);
                            r_ps    <= 32'(r_rec.fsin * u_y);
                            r_state <= B_CMP;
                        end
                    end
                end
                B_CMP: begin
                    if (dot_c < lim) begin
                        r_state <= B_NEXT;
                    end else if (r_kind == K_ALIGN) begin
                        r_uin_x  <= 32'(r_rec.vx);
                        r_uin_y  <= 32'(r_rec.vy);
                        r_ustart <= 1'b1;
                        r_state  <= B_VEL;
                    end else begin
                        r_tsx   <= sat_add(r_tsx, u_x);
                        r_tsy   <= sat_add(r_tsy, u_y);
                        r_state <= B_NEXT;
                    end
                end
                B_VEL: begin
                    if (u_done) begin
                        if (u_nz) begin
                            r_asx <= sat_add(r_asx, u_x);
                            r_asy <= sat_add(r_asy, u_y);
                        end
                        r_state <= B_NEXT;
                    end
                end
                B_NEXT: begin
                    // the closing neighbor of a group starts the heading pass
                    if (r_rec.last) begin
                        r_uin_x  <= r_rsx;
                        r_uin_y  <= r_rsy;
                        r_ustart <= 1'b1;
                        r_state  <= B_FREP;
                    end else begin
                        r_state <= B_IDLE;
                    end
                end
                B_FREP: begin
                    if (u_done) begin
                        r_rux    <= u_x;
                        r_ruy    <= u_y;
                        r_hrep   <= u_nz;
                        r_uin_x  <= r_asx;
                        r_uin_y  <= r_asy;
                        r_ustart <= 1'b1;
                        r_state  <= B_FAL;
                    end
                end
                B_FAL: begin
                    if (u_done) begin
                        r_aux    <= u_x;
                        r_auy    <= u_y;
                        r_hal    <= u_nz;
                        r_uin_x  <= r_tsx;
                        r_uin_y  <= r_tsy;
                        r_ustart <= 1'b1;
                        r_state  <= B_FAT;
                    end
                end
                B_FAT: begin
                    if (u_done) begin
                        r_tux   <= u_x;
                        r_tuy   <= u_y;
                        r_hat   <= u_nz;
                        r_state <= B_MIX;
                    end
                end
                B_MIX: begin
                    r_max   <= 32'($signed({1'b0, w}) * r_aux);
                    r_may   <= 32'($signed({1'b0, w}) * r_auy);
                    r_mtx   <= 32'($signed({1'b0, wc}) * r_tux);
                    r_mty   <= 32'($signed({1'b0, wc}) * r_tuy);
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        if (r_hrep) begin
                            r_dx   <= r_rux;
                            r_dy   <= r_ruy;
                            r_zone <= ZONE_REPEL;
                        end else if (r_hal && r_hat) begin
                            r_dx   <= mix_x;
                            r_dy   <= mix_y;
                            r_zone <= ZONE_MIXED;
                        end else if (r_hal) begin
                            r_dx   <= r_aux;
                            r_dy   <= r_auy;
                            r_zone <= ZONE_ALIGN;
                        end else if (r_hat) begin
                            r_dx   <= r_tux;
                            r_dy   <= r_tuy;
                            r_zone <= ZONE_ATTRACT;
                        end else begin
                            r_dx   <= '0;
                            r_dy   <= '0;
                            r_zone <= ZONE_NONE;
                        end
                        r_rsx   <= '0;
                        r_rsy   <= '0;
                        r_asx   <= '0;
                        r_asy   <= '0;
                        r_tsx   <= '0;
                        r_tsy   <= '0;
                        r_seen  <= 1'b0;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/zonal_flocking_heading_top.sv
// Top level of the zonal flocking heading block: register file, front, queue, back.
// Depends on zfh_pkg, zfh_front, zfh_fifo, zfh_back (and zfh_unit through it).
`timescale 1ns / 1ps

// Streams focal/neighbor pairs and returns one Q1.14 heading per group, on the
// transfer marked last. The front takes a transfer, forms the wrapped offset,
// squared distance and zone compares (wrap, square, push states), then hands a
// record to a two-entry queue; it takes the next transfer only after that push,
// which waits while the queue is full. The back drains records through one
// shared unit-vector engine (one-bit normalize shifts, a 30-step square root
// and 17-step dividers): a neighbor in a zone costs one engine run, one in the
// align zone that passes the view test two, a skipped or out-of-range one none.
// The closing transfer of a group adds three engine runs before the heading
// appears. Sustained rate is set by that engine. The result waits in an output
// register, so the back keeps draining records while it is stalled, until the
// next heading is ready. Program the registers only while the block is idle.

module zonal_flocking_heading_top import zfh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // neighbor stream
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [19:0]          i_focal_x,
    input  logic [19:0]          i_focal_y,
    input  logic signed [15:0]   i_focal_cos,
    input  logic signed [15:0]   i_focal_sin,
    input  logic [19:0]          i_other_x,
    input  logic [19:0]          i_other_y,
    input  logic signed [23:0]   i_other_vx,
    input  logic signed [23:0]   i_other_vy,
    input  logic                 i_is_self,
    input  logic                 i_last,
    // heading results
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [15:0]   o_dir_x,
    output logic signed [15:0]   o_dir_y,
    output logic [2:0]           o_zone_used
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    logic q_push, q_pop, q_full, q_empty;
    t_rec q_in, q_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[AddrWidth-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes land on the access phase of the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repel_radius   <= '0;
            r_cfg.align_radius   <= '0;
            r_cfg.attract_radius <= '0;
            r_cfg.align_weight   <= 15'd8192;
            r_cfg.view_cos_limit <= -16'sd16384;
            r_cfg.mode_bits      <= '0;
            r_cfg.box_width      <= 20'hFFFFF;
            r_cfg.box_height     <= 20'hFFFFF;
        end else if (wr_en) begin
            case (reg_idx)
                REG_REPEL_RADIUS:   r_cfg.repel_radius   <= pwdata[19:0];
                REG_ALIGN_RADIUS:   r_cfg.align_radius   <= pwdata[19:0];
                REG_ATTRACT_RADIUS: r_cfg.attract_radius <= pwdata[19:0];
                REG_ALIGN_WEIGHT:   r_cfg.align_weight   <= pwdata[14:0];
                REG_VIEW_COS_LIMIT: r_cfg.view_cos_limit <= pwdata[15:0];
                REG_MODE_BITS:      r_cfg.mode_bits      <= pwdata[1:0];
                REG_BOX_WIDTH:      r_cfg.box_width      <= pwdata[19:0];
                REG_BOX_HEIGHT:     r_cfg.box_height     <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // Read back, zero-extended; the view limit sign-extends.
    always_comb begin
        case (reg_idx)
            REG_REPEL_RADIUS:   prdata = 32'(r_cfg.repel_radius);
            REG_ALIGN_RADIUS:   prdata = 32'(r_cfg.align_radius);
            REG_ATTRACT_RADIUS: prdata = 32'(r_cfg.attract_radius);
            REG_ALIGN_WEIGHT:   prdata = 32'(r_cfg.align_weight);
            REG_VIEW_COS_LIMIT: prdata = 32'(r_cfg.view_cos_limit);
            REG_MODE_BITS:      prdata = 32'(r_cfg.mode_bits);
            REG_BOX_WIDTH:      prdata = 32'(r_cfg.box_width);
            REG_BOX_HEIGHT:     prdata = 32'(r_cfg.box_height);
            default:            prdata = '0;
        endcase
    end

    zfh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_focal_x   (i_focal_x),
        .i_focal_y   (i_focal_y),
        .i_focal_cos (i_focal_cos),
        .i_focal_sin (i_focal_sin),
        .i_other_x   (i_other_x),
        .i_other_y   (i_other_y),
        .i_other_vx  (i_other_vx),
        .i_other_vy  (i_other_vy),
        .i_is_self   (i_is_self),
        .i_last      (i_last),
        .o_push      (q_push),
        .o_rec       (q_in),
        .i_full      (q_full)
    );

    zfh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    zfh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rec       (q_out),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_dir_x     (o_dir_x),
        .o_dir_y     (o_dir_y),
        .o_zone_used (o_zone_used)
    );

endmodule

FILE: rtl/zfh_checker.sv
// Port-level checks on the heading result channel, bound to the top level.
// Depends on zfh_pkg for the zone codes.
`timescale 1ns / 1ps

module zfh_checker import zfh_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_dir_x,
    input logic signed [15:0] o_dir_y,
    input logic [2:0]         o_zone_used
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_dir_x)
            && $stable(o_dir_y) && $stable(o_zone_used))
        else $error("result changed while stalled");

    a_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_zone_used <= ZONE_ATTRACT)
        else $error("zone code out of range");

    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zone_used == ZONE_NONE |-> o_dir_x == '0 && o_dir_y == '0)
        else $error("empty group gave a nonzero heading");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_dir_x >= -16'sd16384 && o_dir_x <= 16'sd16384
            && o_dir_y >= -16'sd16384 && o_dir_y <= 16'sd16384)
        else $error("heading outside unit range");

endmodule

bind zonal_flocking_heading_top zfh_checker u_zfh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_dir_x     (o_dir_x),
    .o_dir_y     (o_dir_y),
    .o_zone_used (o_zone_used)
);

FILE: bench/zonal_flocking_heading_top_tb.sv
// Self-checking bench for zonal_flocking_heading_top: neighbor streams, APB setup, heading checks.
// Depends on zfh_pkg and the RTL under rtl/; the heading predictor lives in this file.
`timescale 1ns / 1ps

module zonal_flocking_heading_top_tb;
    import zfh_pkg::*;

    typedef struct {
        logic [19:0]        fx, fy;
        logic signed [15:0] fc, fs;
        logic [19:0]        ox, oy;
        logic signed [23:0] vx, vy;
        logic               self_bit, last_bit;
    } t_pair;

    typedef struct {
        logic signed [15:0] dx, dy;
        logic [2:0]         zone;
    } t_heading;

    // Flocking heading predictor plus the queue of headings still owed by the block.
    class heading_board;
        t_cfg     cfg;
        longint   rep_x, rep_y, ali_x, ali_y, att_x, att_y;
        bit       rep_seen;
        t_heading owed[$];
        int       bad;
        int       groups;

        function void clear_sums();
            rep_x = 0; rep_y = 0; ali_x = 0; ali_y = 0; att_x = 0; att_y = 0;
            rep_seen = 0;
        endfunction

        function void reset_state();
            cfg.repel_radius = 0; cfg.align_radius = 0; cfg.attract_radius = 0;
            cfg.align_weight = 15'd8192; cfg.view_cos_limit = -16'sd16384;
            cfg.mode_bits = 0; cfg.box_width = 20'hFFFFF; cfg.box_height = 20'hFFFFF;
            clear_sums();
            bad = 0;
            groups = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function bit unit(longint x, longint y, output longint ux, output longint uy);
            longint unsigned ax, ay, m, q, cx, cy;
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            m = ax > ay ? ax : ay;
            ux = 0; uy = 0;
            if (m == 0) return 0;
            while (m >= (64'd1 << 21)) begin ax >>= 1; ay >>= 1; m >>= 1; end
            while (m < (64'd1 << 20)) begin ax <<= 1; ay <<= 1; m <<= 1; end
            q = root((ax * ax + ay * ay) << 16);
            cx = ((ax << 22) + q / 2) / q;
            cy = ((ay << 22) + q / 2) / q;
            if (cx > 16384) cx = 16384;
            if (cy > 16384) cy = 16384;
            ux = x < 0 ? -longint'(cx) : longint'(cx);
            uy = y < 0 ? -longint'(cy) : longint'(cy);
            return 1;
        endfunction

        function longint round14(longint p);
            longint m;
            m = ((p < 0 ? -p : p) + 8192) >>> 14;
            if (m > 16384) m = 16384;
            return p < 0 ? -m : m;
        endfunction

        function bit seen(longint c, longint s, longint ux, longint uy);
            longint d;
            d = c * ux + s * uy;
            if (d > (64'sd1 << 28)) d = 64'sd1 << 28;
            if (d < -(64'sd1 << 28)) d = -(64'sd1 << 28);
            return !(d < longint'(cfg.view_cos_limit) * 16384);
        endfunction

        function longint wrap(longint r, longint w);
            if (2 * r > w) return r - w;
            if (2 * r <= -w) return r + w;
            return r;
        endfunction

        // Note an accepted pair; queue a heading when it closes a group.
        function void note_pair(t_pair p);
            longint rx, ry, ux, uy, vx2, vy2, ax, ay, tx, ty, w;
            longint unsigned d2, rd, ra, rat;
            bit vic, hal, hat;
            t_heading h;
            vic = cfg.mode_bits[MODE_VICSEK];
            if (!p.self_bit) begin
                rx = longint'(p.ox) - longint'(p.fx);
                ry = longint'(p.oy) - longint'(p.fy);
                if (cfg.mode_bits[MODE_WRAP]) begin
                    rx = wrap(rx, longint'(cfg.box_width));
                    ry = wrap(ry, longint'(cfg.box_height));
                end
                d2 = rx * rx + ry * ry;
                rd = longint'(cfg.repel_radius) * longint'(cfg.repel_radius);
                ra = longint'(cfg.align_radius) * longint'(cfg.align_radius);
                rat = longint'(cfg.attract_radius) * longint'(cfg.attract_radius);
                if (d2 != 0) begin
                    if (!vic && cfg.repel_radius != 0 && d2 < rd) begin
                        void'(unit(rx, ry, ux, uy));
                        rep_x = clamp32(rep_x - ux);
                        rep_y = clamp32(rep_y - uy);
                        rep_seen = 1;
                    end else if (d2 < ra && (vic || (!rep_seen && cfg.align_radius != 0
                                                     && d2 >= rd))) begin
                        void'(unit(rx, ry, ux, uy));
                        if (seen(p.fc, p.fs, ux, uy) && unit(p.vx, p.vy, vx2, vy2)) begin
                            ali_x = clamp32(ali_x + vx2);
                            ali_y = clamp32(ali_y + vy2);
                        end
                    end else if (!vic && !rep_seen && cfg.attract_radius != 0 &&
                                 d2 >= rd && d2 >= ra && d2 < rat) begin
                        void'(unit(rx, ry, ux, uy));
                        if (seen(p.fc, p.fs, ux, uy)) begin
                            att_x = clamp32(att_x + ux);
                            att_y = clamp32(att_y + uy);
                        end
                    end
                end
            end
            if (!p.last_bit) return;
            hal = unit(ali_x, ali_y, ax, ay);
            hat = unit(att_x, att_y, tx, ty);
            h.dx = 0; h.dy = 0; h.zone = ZONE_NONE;
            if (unit(rep_x, rep_y, ux, uy)) begin
                h.dx = 16'(ux); h.dy = 16'(uy); h.zone = ZONE_REPEL;
            end else if (hal && hat) begin
                w = cfg.align_weight > 16384 ? 16384 : longint'(cfg.align_weight);
                h.dx = 16'(round14(w * ax + (16384 - w) * tx));
                h.dy = 16'(round14(w * ay + (16384 - w) * ty));
                h.zone = ZONE_MIXED;
            end else if (hal) begin
                h.dx = 16'(ax); h.dy = 16'(ay); h.zone = ZONE_ALIGN;
            end else if (hat) begin
                h.dx = 16'(tx); h.dy = 16'(ty); h.zone = ZONE_ATTRACT;
            end
            owed = {owed, h};
            clear_sums();
        endfunction

        function void check_heading(t_heading got);
            t_heading e;
            groups++;
            if (owed.size() == 0) begin
                bad++;
                if (bad <= 10) $display("unexpected heading %0d %0d zone %0d",
                                        got.dx, got.dy, got.zone);
                return;
            end
            e = owed.pop_front();
            if (e.dx !== got.dx || e.dy !== got.dy || e.zone !== got.zone) begin
                bad++;
                if (bad <= 10)
                    $display("heading mismatch: exp %0d %0d zone %0d, got %0d %0d zone %0d",
                             e.dx, e.dy, e.zone, got.dx, got.dy, got.zone);
            end
        endfunction
    endclass

    logic                 i_clk = 0, i_rst_n = 0;
    logic                 psel = 0, penable = 0, pwrite = 0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [31:0]          pwdata = '0, prdata;
    logic                 pready;
    logic                 i_in_valid = 0, o_in_stall;
    logic [19:0]          i_focal_x = 0, i_focal_y = 0, i_other_x = 0, i_other_y = 0;
    logic signed [15:0]   i_focal_cos = 0, i_focal_sin = 0;
    logic signed [23:0]   i_other_vx = 0, i_other_vy = 0;
    logic                 i_is_self = 0, i_last = 0;
    logic                 o_out_valid, i_out_stall = 0;
    logic signed [15:0]   o_dir_x, o_dir_y;
    logic [2:0]           o_zone_used;

    heading_board board;
    int  hold_cycles = 0;    // forced long stall of the receiver
    int  idle_cycles = 0;    // occasional long random stall of the receiver
    bit  stall_random = 0;
    int  pairs_sent = 0;

    zonal_flocking_heading_top dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Check each heading transfer at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_heading('{o_dir_x, o_dir_y, o_zone_used});
    end

    // Receiver stall: a long hold-off when asked, else short random gaps, some long.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1;
        end else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            i_out_stall <= 1;
        end else if (stall_random) begin
            if ($urandom_range(0, 199) == 0)
                idle_cycles <= $urandom_range(20, 150);
            i_out_stall <= ($urandom_range(0, 99) < 30) ||
                           ($urandom_range(0, 999) < 3);
        end else begin
            i_out_stall <= 0;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= AddrWidth'(idx) << 2; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_REPEL_RADIUS:   board.cfg.repel_radius = val[19:0];
            REG_ALIGN_RADIUS:   board.cfg.align_radius = val[19:0];
            REG_ATTRACT_RADIUS: board.cfg.attract_radius = val[19:0];
            REG_ALIGN_WEIGHT:   board.cfg.align_weight = val[14:0];
            REG_VIEW_COS_LIMIT: board.cfg.view_cos_limit = val[15:0];
            REG_MODE_BITS:      board.cfg.mode_bits = val[1:0];
            REG_BOX_WIDTH:      board.cfg.box_width = val[19:0];
            default:            board.cfg.box_height = val[19:0];
        endcase
    endtask

    // Offer one pair, hold it until the transfer happens, then drop valid.
    task automatic send_pair(input t_pair p, input bit gaps);
        int g;
        if (gaps) begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
            repeat (g) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_focal_x <= p.fx; i_focal_y <= p.fy; i_focal_cos <= p.fc; i_focal_sin <= p.fs;
        i_other_x <= p.ox; i_other_y <= p.oy; i_other_vx <= p.vx; i_other_vy <= p.vy;
        i_is_self <= p.self_bit; i_last <= p.last_bit;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_pair(p);
        pairs_sent++;
        @(negedge i_clk);
        i_in_valid <= 0;
    endtask

    // Wait for every owed heading, then let the back pipeline settle.
    task automatic drain();
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_q14();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    // A pair whose neighbor usually sits near the focal agent, so it often lands in some zone.
    function automatic t_pair near_pair(int spread, bit last_bit);
        t_pair p;
        p.fx = 20'($urandom); p.fy = 20'($urandom);
        p.ox = p.fx + 20'($urandom_range(0, 2 * spread) - spread);
        p.oy = p.fy + 20'($urandom_range(0, 2 * spread) - spread);
        p.fc = rand_q14(); p.fs = rand_q14();
        case ($urandom_range(0, 7))
            0: begin p.vx = 0; p.vy = 0; end
            1: begin p.vx = 24'h800000; p.vy = 24'h7FFFFF; end
            default: begin p.vx = 24'($urandom); p.vy = 24'($urandom); end
        endcase
        if ($urandom_range(0, 9) == 0) p.ox = 20'($urandom);
        if ($urandom_range(0, 19) == 0) begin p.ox = p.fx; p.oy = p.fy; end
        p.self_bit = ($urandom_range(0, 24) == 0);
        p.last_bit = last_bit;
        return p;
    endfunction

    task automatic random_config(input int phase);
        int r;
        r = $urandom_range(4, 3000);
        reg_write(REG_REPEL_RADIUS, phase == 0 ? 0 : $urandom_range(0, r / 3));
        reg_write(REG_ALIGN_RADIUS, phase == 1 ? 0 : $urandom_range(r / 3, 2 * r / 3));
        reg_write(REG_ATTRACT_RADIUS, phase == 2 ? 20'hFFFFF : $urandom_range(0, r));
        reg_write(REG_ALIGN_WEIGHT, phase == 3 ? 32'h7FFF : $urandom_range(0, 16384));
        reg_write(REG_VIEW_COS_LIMIT, phase == 4 ? 32'h4000 :
                  32'($signed(16'($urandom_range(0, 32768))) - 16'sd16384));
        reg_write(REG_MODE_BITS, $urandom_range(0, 3));
        reg_write(REG_BOX_WIDTH, phase == 5 ? 1 : $urandom_range(1, 4000));
        reg_write(REG_BOX_HEIGHT, phase == 6 ? 20'hFFFFF : $urandom_range(1, 4000));
    endtask

    initial begin
        t_pair p;
        int n, glen;
        board = new();
        board.reset_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, each zone, self and coincident pairs, velocity zero.
        reg_write(REG_REPEL_RADIUS, 100);
        reg_write(REG_ALIGN_RADIUS, 400);
        reg_write(REG_ATTRACT_RADIUS, 20'hFFFFF);
        reg_write(REG_ALIGN_WEIGHT, 16384);
        reg_write(REG_VIEW_COS_LIMIT, 32'hFFFFC000);
        reg_write(REG_MODE_BITS, 0);
        reg_write(REG_BOX_WIDTH, 20'hFFFFF);
        reg_write(REG_BOX_HEIGHT, 20'hFFFFF);
        send_pair('{0, 0, 16384, 0, 20'hFFFFF, 20'hFFFFF, 24'h7FFFFF, 24'h800000, 0, 1}, 0);
        send_pair('{500, 500, 0, 16384, 700, 500, 100, 0, 0, 0}, 0);
        send_pair('{500, 500, -16384, -16384, 550, 450, 0, 0, 0, 0}, 0);
        send_pair('{500, 500, 0, 0, 500, 500, 5, 5, 0, 1}, 0);
        send_pair('{500, 500, 16384, 0, 530, 500, 0, 0, 0, 0}, 0);
        send_pair('{500, 500, 16384, 0, 700, 500, 9, 9, 0, 1}, 0);
        send_pair('{9, 9, 16384, 0, 10, 9, 1, 1, 1, 1}, 0);
        send_pair('{20'hFFFFF, 0, 16384, 0, 0, 20'hFFFFF, 24'h800000, 1, 0, 1}, 0);
        drain();
        reg_write(REG_MODE_BITS, 3);
        reg_write(REG_BOX_WIDTH, 1000);
        reg_write(REG_BOX_HEIGHT, 1);
        send_pair('{10, 10, 16384, 0, 990, 10, 24'h7FFFFF, 24'h7FFFFF, 0, 0}, 0);
        send_pair('{10, 10, 16384, 16384, 510, 10, -3, 4, 0, 1}, 0);
        drain();
        reg_write(REG_MODE_BITS, 1);
        reg_write(REG_VIEW_COS_LIMIT, 16384);
        reg_write(REG_ALIGN_WEIGHT, 0);
        send_pair('{10, 10, 16384, 0, 350, 10, 1, 0, 0, 0}, 0);
        send_pair('{10, 10, -16384, 0, 1000, 10, 1, 0, 0, 1}, 0);
        drain();

        // Random phases with well-formed groups, gaps and stalls on both sides.
        stall_random = 1;
        for (int ph = 0; ph < 10 && pairs_sent < 1650; ph++) begin
            random_config(ph);
            n = 0;
            while (n < 160) begin
                glen = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
                for (int k = 0; k < glen; k++) begin
                    p = near_pair(board.cfg.attract_radius > 3000 ? 3000 :
                                  board.cfg.attract_radius + 10, k == glen - 1);
                    send_pair(p, ph != 2);
                    n++;
                end
                if (ph == 4 && n > 80 && n - glen <= 80) begin
                    // Hold the receiver off long enough that the input backs up.
                    hold_cycles = 3000;
                end
            end
            drain();
        end
        drain();
        $display("Covered %0d pairs over ten register settings, %0d headings checked.",
                 pairs_sent, board.groups);
        if (board.bad == 0 && board.owed.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d failures, %0d headings still owed", board.bad, board.owed.size());
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
